// ===== hdl/ahm_pkg.sv =====
// Package: widths, constants and the 2^x table for the absolute humidity pipeline.
package ahm_pkg;

  // Port field widths
  localparam int TEMP_W = 15;
  localparam int RH_W   = 14;
  localparam int AH_W   = 21;

  // Divider geometry: numerator is DEN_W + DIV_Q_W bits, quotient DIV_Q_W bits
  localparam int DEN_W      = 16;
  localparam int DIV_Q_W    = 24;
  localparam int DIV_N_W    = DEN_W + DIV_Q_W;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = DIV_Q_W / DIV_STEPS;

  // Exponent datapath
  localparam int MAG_W   = 36;
  localparam int Y_W     = 24;
  localparam int FRAC_W  = 16;
  localparam int EXPO_W  = Y_W - FRAC_W;
  localparam int SHIFT_W = 6;

  // 2^f table
  localparam int EXP_TABLE_ENTRIES = 256;
  localparam int EXP_IDX_W  = $clog2(EXP_TABLE_ENTRIES);
  localparam int EXP_AW     = $clog2(EXP_TABLE_ENTRIES + 1);
  localparam int EXP_W      = 32;
  localparam int EXP_TERMS  = 24;
  localparam int MANT_SHIFT = 14;
  localparam int MANT_W     = 18;

  // Scaling datapath
  localparam int U_W       = RH_W + MANT_W;
  localparam int K_AH_W    = 30;
  localparam int PROD_W    = U_W + K_AH_W;
  localparam int PROD_DROP = 22;

  // Stage counts of the sub-pipelines and the whole block
  localparam int POW2_LAT  = 4;
  localparam int SCALE_LAT = 4;
  localparam int AH_LAT    = 1 + DIV_STAGES + 1 + POW2_LAT + SCALE_LAT + DIV_STAGES + 1;

  // Fixed-point constants
  localparam logic [20:0]         K_EXP2   = 21'd1665944;   // 17.62*log2(e), Q16
  localparam logic [K_AH_W-1:0]   K_AH     = 30'd868004921; // 216.7*6.112*10, Q16
  localparam logic [DEN_W-1:0]    DEN1_OFS = 16'd24312;
  localparam logic [DEN_W-1:0]    DEN2_OFS = 16'd27315;
  localparam logic [AH_W-1:0]     OUT_MAX  = {AH_W{1'b1}};
  localparam logic signed [8:0]   SHIFT_BIAS = 9'sd10;      // 32 - PROD_DROP
  localparam logic [63:0]         LN2_Q30  = 64'd744261118;
  localparam logic [63:0]         ONE_Q30  = 64'd1073741824;

  typedef logic [EXP_W-1:0] exp_rom_t [EXP_TABLE_ENTRIES+1];

  // Entry i holds 2^(i/EXP_TABLE_ENTRIES) in Q30, from a truncated exp series.
  function automatic exp_rom_t build_exp_rom();
    exp_rom_t    rom;
    logic [63:0] z;
    logic [63:0] term;
    logic [63:0] sum;
    int          i;
    int          k;
    for (i = 0; i <= EXP_TABLE_ENTRIES; i++) begin
      z    = (64'(i) * LN2_Q30) / 64'(EXP_TABLE_ENTRIES);
      term = ONE_Q30;
      sum  = ONE_Q30;
      for (k = 1; k <= EXP_TERMS; k++) begin
        term = ((term * z) >> 30) / 64'(k);
        sum  = sum + term;
      end
      rom[i] = sum[EXP_W-1:0];
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP_ROM = build_exp_rom();

  // Side data that rides along the exponent path into the scaling stages
  typedef struct packed {
    logic [SHIFT_W-1:0] shift;
    logic               zero;
    logic [DEN_W-1:0]   den;
    logic [RH_W-1:0]    rh;
  } scale_ctl_t;

endpackage

// ===== hdl/ahm_udiv.sv =====
// Pipelined restoring divider, a few quotient bits per stage.
module ahm_udiv (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [ahm_pkg::DIV_N_W-1:0]   num_i,
  input  logic [ahm_pkg::DEN_W-1:0]     den_i,
  output logic                          valid_o,
  output logic [ahm_pkg::DIV_Q_W-1:0]   quot_o,
  output logic                          rem_nz_o
);
  import ahm_pkg::*;

  // Caller keeps num_i below den_i * 2^DIV_Q_W.
  function automatic logic [DEN_W+DIV_Q_W-1:0] div_steps(
    input logic [DEN_W-1:0]   rem,
    input logic [DIV_Q_W-1:0] nq,
    input logic [DEN_W-1:0]   den
  );
    logic [DEN_W-1:0]   r;
    logic [DIV_Q_W-1:0] b;
    logic [DEN_W:0]     t;
    logic               ge;
    int                 k;
    r = rem;
    b = nq;
    for (k = 0; k < DIV_STEPS; k++) begin
      t  = {r, b[DIV_Q_W-1]};
      ge = (t >= {1'b0, den});
      b  = {b[DIV_Q_W-2:0], ge};
      r  = ge ? DEN_W'(t - {1'b0, den}) : t[DEN_W-1:0];
    end
    return {r, b};
  endfunction

  logic [DEN_W-1:0]   rem_q [DIV_STAGES];
  logic [DIV_Q_W-1:0] nq_q  [DIV_STAGES];
  logic [DEN_W-1:0]   den_q [DIV_STAGES];
  logic               vld_q [DIV_STAGES];

  logic [DEN_W-1:0]   rem_in [DIV_STAGES];
  logic [DIV_Q_W-1:0] nq_in  [DIV_STAGES];
  logic [DEN_W-1:0]   den_in [DIV_STAGES];
  logic               vld_in [DIV_STAGES];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    if (g == 0) begin : g_first
      assign rem_in[g] = num_i[DIV_N_W-1 -: DEN_W];
      assign nq_in[g]  = num_i[DIV_Q_W-1:0];
      assign den_in[g] = den_i;
      assign vld_in[g] = valid_i;
    end else begin : g_next
      assign rem_in[g] = rem_q[g-1];
      assign nq_in[g]  = nq_q[g-1];
      assign den_in[g] = den_q[g-1];
      assign vld_in[g] = vld_q[g-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else begin
        vld_q[g] <= vld_in[g];
      end
    end

    always_ff @(posedge clk_i) begin
      {rem_q[g], nq_q[g]} <= div_steps(rem_in[g], nq_in[g], den_in[g]);
      den_q[g]            <= den_in[g];
    end
  end

  assign valid_o  = vld_q[DIV_STAGES-1];
  assign quot_o   = nq_q[DIV_STAGES-1];
  assign rem_nz_o = |rem_q[DIV_STAGES-1];

`ifndef SYNTHESIS
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[DIV_STAGES-1] |-> (rem_q[DIV_STAGES-1] < den_q[DIV_STAGES-1]))
    else $error("divider remainder not below divisor");
`endif

endmodule

// ===== hdl/ahm_pow2.sv =====
// 2^f lookup with linear interpolation, four register stages.
module ahm_pow2 (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic [ahm_pkg::FRAC_W-1:0]   frac_i,
  output logic                         valid_o,
  output logic [ahm_pkg::MANT_W-1:0]   mant_o
);
  import ahm_pkg::*;

  localparam int P_W = FRAC_W + EXP_IDX_W;
  localparam logic [MANT_W-1:0] MANT_LO = MANT_W'(1) << 16;
  localparam logic [MANT_W-1:0] MANT_HI = MANT_W'(1) << 17;

  logic [P_W-1:0]       p;
  logic [EXP_W-1:0]     diff;
  logic [EXP_W+FRAC_W-1:0] dprod;
  logic [EXP_W:0]       msum;

  logic                 vld_a_q, vld_b_q, vld_c_q, vld_d_q;
  logic [EXP_IDX_W-1:0] idx_a_q;
  logic [FRAC_W-1:0]    r_a_q, r_b_q;
  logic [EXP_W-1:0]     t0_b_q, t1_b_q, t0_c_q, ipol_c_q;
  logic [MANT_W-1:0]    mant_q;

  assign p     = P_W'(frac_i) * P_W'(EXP_TABLE_ENTRIES);
  assign diff  = (t1_b_q > t0_b_q) ? (t1_b_q - t0_b_q) : '0;
  assign dprod = (EXP_W+FRAC_W)'(diff) * (EXP_W+FRAC_W)'(r_b_q);
  assign msum  = {1'b0, t0_c_q} + {1'b0, ipol_c_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
      vld_d_q <= 1'b0;
    end else begin
      vld_a_q <= valid_i;
      vld_b_q <= vld_a_q;
      vld_c_q <= vld_b_q;
      vld_d_q <= vld_c_q;
    end
  end

  always_ff @(posedge clk_i) begin
    // split scaled fraction into table index and interpolation weight
    idx_a_q  <= p[P_W-1:FRAC_W];
    r_a_q    <= p[FRAC_W-1:0];
    t0_b_q   <= EXP_ROM[EXP_AW'(idx_a_q)];
    t1_b_q   <= EXP_ROM[EXP_AW'(idx_a_q) + EXP_AW'(1)];
    r_b_q    <= r_a_q;
    t0_c_q   <= t0_b_q;
    ipol_c_q <= dprod[EXP_W+FRAC_W-1:FRAC_W];
    mant_q   <= msum[MANT_SHIFT +: MANT_W];
  end

  assign valid_o = vld_d_q;
  assign mant_o  = mant_q;

`ifndef SYNTHESIS
  a_mant_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_d_q |-> (mant_q >= MANT_LO) && (mant_q <= MANT_HI))
    else $error("interpolated 2^f outside [1, 2]");
`endif

endmodule

// ===== hdl/ahm_scale.sv =====
// Scaling stages: multiply by humidity and constant, apply exponent shift, flag saturation.
module ahm_scale (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic [ahm_pkg::MANT_W-1:0]   mant_i,
  input  ahm_pkg::scale_ctl_t          ctl_i,
  output logic                         valid_o,
  output logic [ahm_pkg::DIV_N_W-1:0]  num_o,
  output logic [ahm_pkg::DEN_W-1:0]    den_o,
  output logic                         sat_o
);
  import ahm_pkg::*;

  logic                 vld1_q, vld2_q, vld3_q, vld4_q;
  logic [U_W-1:0]       u1_q;
  logic [SHIFT_W-1:0]   sh1_q, sh2_q;
  logic                 zero1_q, zero2_q;
  logic [DEN_W-1:0]     den1_q, den2_q, den3_q, den4_q;
  logic [PROD_W-1:0]    prod2_q;
  logic [DIV_N_W-1:0]   a3_q, num4_q;
  logic                 sat4_q;
  logic [DIV_N_W-1:0]   prod_hi;
  logic                 sat;

  assign prod_hi = DIV_N_W'(prod2_q >> PROD_DROP);
  assign sat     = a3_q >= (DIV_N_W'(den3_q) << AH_W);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
    end else begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
      vld4_q <= vld3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    u1_q    <= U_W'(ctl_i.rh) * U_W'(mant_i);
    sh1_q   <= ctl_i.shift;
    zero1_q <= ctl_i.zero;
    den1_q  <= ctl_i.den;

    prod2_q <= PROD_W'(K_AH) * PROD_W'(u1_q);
    sh2_q   <= sh1_q;
    zero2_q <= zero1_q;
    den2_q  <= den1_q;

    // drop the value entirely once the exponent pushes it past the word
    a3_q    <= zero2_q ? '0 : (prod_hi >> sh2_q);
    den3_q  <= den2_q;

    // feed zero on saturation so the divider's range holds
    num4_q  <= sat ? '0 : a3_q;
    sat4_q  <= sat;
    den4_q  <= den3_q;
  end

  assign valid_o = vld4_q;
  assign num_o   = num4_q;
  assign den_o   = den4_q;
  assign sat_o   = sat4_q;

`ifndef SYNTHESIS
  a_zero_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld4_q && $past(ctl_i.zero, SCALE_LAT)) |-> (num4_q == '0) && !sat4_q)
    else $error("underflowed exponent did not give a zero numerator");
`endif

endmodule

// ===== hdl/absolute_humidity_from_temp_rh.sv =====
// Top level: absolute humidity from temperature and relative humidity.
// Takes one sample on every clock edge where start is high; busy is never
// raised. Each result is on valid_o for one cycle, after the sample has passed
// through every register stage of the pipeline; results come in order, one per
// sample. The pipeline is made of the two pipelined dividers (six stages of
// four quotient bits each), the four-stage 2^f table interpolator and the four
// scaling stages with their 30x32 multiply, plus the input register, the
// exponent split register and the output register.
// Results saturate at 2097151 mg/m^3 and there is no reset sweep: the block
// accepts samples from the first cycle after reset.
module absolute_humidity_from_temp_rh (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [ahm_pkg::TEMP_W-1:0] temp_centi_c_i,
  input  logic [ahm_pkg::RH_W-1:0]          rh_centi_pct_i,
  output logic                              valid_o,
  output logic [ahm_pkg::AH_W-1:0]          abs_humidity_mg_m3_o
);
  import ahm_pkg::*;

  typedef struct packed {
    logic             neg;
    logic [DEN_W-1:0] den;
    logic [RH_W-1:0]  rh;
  } d1_side_t;

  // input stage
  logic [TEMP_W-1:0] abs_tc;
  logic [MAG_W-1:0]  mag;
  logic [DEN_W-1:0]  tc16;
  logic              s1_vld_q;
  logic [DIV_N_W-1:0] s1_num_q;
  logic [DEN_W-1:0]  s1_den1_q;
  d1_side_t          s1_side_q;

  // first divider and side delay
  logic              d1_vld;
  logic [DIV_Q_W-1:0] d1_quot;
  logic              d1_rem_nz;
  d1_side_t          d1_side_q [DIV_STAGES];
  d1_side_t          d1_side;

  // exponent split stage
  logic [Y_W-1:0]    ymag, y;
  logic signed [EXPO_W-1:0] n;
  logic signed [8:0] sh_full;
  logic              s2_vld_q;
  logic [FRAC_W-1:0] s2_frac_q;
  scale_ctl_t        s2_ctl_q;

  // 2^f and scaling
  logic              p2_vld;
  logic [MANT_W-1:0] p2_mant;
  scale_ctl_t        p2_ctl_q [POW2_LAT];
  logic              sc_vld;
  logic [DIV_N_W-1:0] sc_num;
  logic [DEN_W-1:0]  sc_den;
  logic              sc_sat;

  // second divider and output
  logic              d2_vld;
  logic [DIV_Q_W-1:0] d2_quot;
  logic              d2_rem_nz;
  logic              d2_sat_q [DIV_STAGES];
  logic              out_vld_q;
  logic [AH_W-1:0]   out_ah_q;

  assign busy = 1'b0;

  assign abs_tc = temp_centi_c_i[TEMP_W-1] ? TEMP_W'(-temp_centi_c_i) : temp_centi_c_i;
  assign mag    = MAG_W'(K_EXP2) * MAG_W'(abs_tc);
  assign tc16   = {temp_centi_c_i[TEMP_W-1], temp_centi_c_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= start && !busy;
      s2_vld_q  <= d1_vld;
      out_vld_q <= d2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_num_q      <= DIV_N_W'(mag);
    s1_den1_q     <= tc16 + DEN1_OFS;
    s1_side_q.neg <= temp_centi_c_i[TEMP_W-1];
    s1_side_q.den <= tc16 + DEN2_OFS;
    s1_side_q.rh  <= rh_centi_pct_i;
  end

  ahm_udiv u_div_exp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s1_vld_q),
    .num_i    (s1_num_q),
    .den_i    (s1_den1_q),
    .valid_o  (d1_vld),
    .quot_o   (d1_quot),
    .rem_nz_o (d1_rem_nz)
  );

  always_ff @(posedge clk_i) begin
    d1_side_q[0] <= s1_side_q;
    for (int i = 1; i < DIV_STAGES; i++) begin
      d1_side_q[i] <= d1_side_q[i-1];
    end
  end
  assign d1_side = d1_side_q[DIV_STAGES-1];

  // floor division for a negative numerator: round the magnitude up
  assign ymag    = d1_quot + DIV_Q_W'(d1_rem_nz);
  assign y       = d1_side.neg ? -ymag : d1_quot;
  assign n       = $signed(y[Y_W-1:FRAC_W]);
  assign sh_full = SHIFT_BIAS - {n[EXPO_W-1], n};

  always_ff @(posedge clk_i) begin
    s2_frac_q      <= y[FRAC_W-1:0];
    s2_ctl_q.shift <= sh_full[SHIFT_W-1:0];
    s2_ctl_q.zero  <= (n < -8'sd31);
    s2_ctl_q.den   <= d1_side.den;
    s2_ctl_q.rh    <= d1_side.rh;
  end

  ahm_pow2 u_pow2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_vld_q),
    .frac_i  (s2_frac_q),
    .valid_o (p2_vld),
    .mant_o  (p2_mant)
  );

  always_ff @(posedge clk_i) begin
    p2_ctl_q[0] <= s2_ctl_q;
    for (int i = 1; i < POW2_LAT; i++) begin
      p2_ctl_q[i] <= p2_ctl_q[i-1];
    end
  end

  ahm_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (p2_vld),
    .mant_i  (p2_mant),
    .ctl_i   (p2_ctl_q[POW2_LAT-1]),
    .valid_o (sc_vld),
    .num_o   (sc_num),
    .den_o   (sc_den),
    .sat_o   (sc_sat)
  );

  ahm_udiv u_div_ah (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (sc_vld),
    .num_i    (sc_num),
    .den_i    (sc_den),
    .valid_o  (d2_vld),
    .quot_o   (d2_quot),
    .rem_nz_o (d2_rem_nz)
  );

  always_ff @(posedge clk_i) begin
    d2_sat_q[0] <= sc_sat;
    for (int i = 1; i < DIV_STAGES; i++) begin
      d2_sat_q[i] <= d2_sat_q[i-1];
    end
  end

  // remainder of the final division is not needed: truncate toward zero
  always_ff @(posedge clk_i) begin
    out_ah_q <= d2_sat_q[DIV_STAGES-1] ? OUT_MAX : d2_quot[AH_W-1:0];
  end

  assign valid_o              = out_vld_q;
  assign abs_humidity_mg_m3_o = out_ah_q;

`ifndef SYNTHESIS
  a_dry_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && ($past(rh_centi_pct_i, AH_LAT) == '0)) |-> (out_ah_q == '0))
    else $error("zero humidity transaction gave a nonzero result");
  a_sat_has_no_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (d2_vld && d2_sat_q[DIV_STAGES-1]) |-> (d2_quot == '0) && !d2_rem_nz)
    else $error("saturated transaction reached the divider with a numerator");
`endif

endmodule

// ===== tb/tb_absolute_humidity_from_temp_rh.sv =====
// Testbench for the absolute humidity pipeline: corner table, then random samples vs a predictor.
`timescale 1ns / 100ps

module tb_absolute_humidity_from_temp_rh;

  localparam int             TEMP_W         = ahm_pkg::TEMP_W;
  localparam int             RH_W           = ahm_pkg::RH_W;
  localparam int             AH_W           = ahm_pkg::AH_W;
  localparam int             POW2_ENTRIES   = ahm_pkg::EXP_TABLE_ENTRIES;
  localparam longint         EXPO_GAIN_Q16  = 64'sd1665944;   // 17.62*log2(e)
  localparam logic [63:0]    AH_GAIN_Q16    = 64'd868004921;  // 216.7*6.112*10
  localparam logic [63:0]    LN2_Q30_C      = 64'd744261118;
  localparam logic [63:0]    UNITY_Q30      = 64'd1073741824;
  localparam logic [AH_W-1:0] AH_CEIL       = {AH_W{1'b1}};
  localparam int             CORNER_COUNT   = 22;
  localparam int             RANDOM_PER_PHASE = 225;
  localparam int             DRAIN_CYCLES   = 40;
  localparam int             WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic [RH_W-1:0]          rh;
    logic                     typed;
    logic [AH_W-1:0]          ah;
  } ah_corner_t;

  // Typed rows: no humidity gives zero, deep cold rounds to zero, hot and wet saturates.
  localparam ah_corner_t AH_CORNERS [CORNER_COUNT] = '{
    '{-15'sd16384, 14'd0,     1'b1, 21'd0},
    '{-15'sd16384, 14'd16383, 1'b1, 21'd0},
    '{15'sd16383,  14'd16383, 1'b1, AH_CEIL},
    '{15'sd16383,  14'd10000, 1'b1, AH_CEIL},
    '{15'sd16383,  14'd0,     1'b1, 21'd0},
    '{15'sd12500,  14'd0,     1'b1, 21'd0},
    '{15'sd12500,  14'd10000, 1'b0, 21'd0},
    '{15'sd12501,  14'd10000, 1'b0, 21'd0},
    '{15'sd12500,  14'd16383, 1'b0, 21'd0},
    '{-15'sd4000,  14'd10000, 1'b0, 21'd0},
    '{-15'sd4001,  14'd10000, 1'b0, 21'd0},
    '{-15'sd4000,  14'd1,     1'b0, 21'd0},
    '{15'sd0,      14'd10000, 1'b0, 21'd0},
    '{15'sd0,      14'd1,     1'b0, 21'd0},
    '{-15'sd1,     14'd10000, 1'b0, 21'd0},
    '{15'sd1,      14'd10000, 1'b0, 21'd0},
    '{15'sd2500,   14'd5000,  1'b0, 21'd0},
    '{15'sd2500,   14'd10001, 1'b0, 21'd0},
    '{15'sd2500,   14'd16383, 1'b0, 21'd0},
    '{-15'sd8192,  14'd8192,  1'b0, 21'd0},
    '{15'sd8191,   14'd8191,  1'b0, 21'd0},
    '{15'sd10000,  14'd10000, 1'b0, 21'd0}
  };

  logic                     clk_i          = 1'b0;
  logic                     rst_ni         = 1'b0;
  logic                     start          = 1'b0;
  logic                     busy;
  logic signed [TEMP_W-1:0] temp_centi_c_i = '0;
  logic [RH_W-1:0]          rh_centi_pct_i = '0;
  logic                     valid_o;
  logic [AH_W-1:0]          abs_humidity_mg_m3_o;

  logic [63:0]     pow2_q30 [0:POW2_ENTRIES];
  logic [AH_W-1:0] ah_expected [$];
  logic [AH_W-1:0] ah_want;
  int              mismatch_count = 0;
  int              results_seen   = 0;
  int              samples_sent   = 0;
  int              quiet_cycles   = 0;

  absolute_humidity_from_temp_rh u_top (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .start                (start),
    .busy                 (busy),
    .temp_centi_c_i       (temp_centi_c_i),
    .rh_centi_pct_i       (rh_centi_pct_i),
    .valid_o              (valid_o),
    .abs_humidity_mg_m3_o (abs_humidity_mg_m3_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic longint floor_quot(input longint num, input longint den);
    if (num >= 0) return num / den;
    return -((-num + den - 1) / den);
  endfunction

  function automatic logic [AH_W-1:0] ah_predict(input logic signed [TEMP_W-1:0] temp,
                                                 input logic [RH_W-1:0] rh);
    longint      tc;
    longint      expo_q16;
    longint      whole;
    logic [63:0] frac;
    logic [63:0] pos;
    logic [63:0] idx;
    logic [63:0] rem;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] slope;
    logic [63:0] mant;
    logic [63:0] prod;
    logic [63:0] kelvin;
    logic [63:0] quot;
    logic [63:0] ah;
    longint      sh;
    tc       = longint'(temp);
    expo_q16 = floor_quot(EXPO_GAIN_Q16 * tc, 64'sd24312 + tc);
    whole    = floor_quot(expo_q16, 64'sd65536);
    frac     = 64'(expo_q16 - whole * 64'sd65536);
    // interpolate 2^frac between neighboring table entries
    pos      = frac * 64'(POW2_ENTRIES);
    idx      = pos >> 16;
    rem      = pos & 64'hFFFF;
    lo       = pow2_q30[idx];
    hi       = pow2_q30[idx + 1];
    slope    = (hi > lo) ? (hi - lo) : 64'd0;
    mant     = lo + ((slope * rem) >> 16);
    prod     = (AH_GAIN_Q16 * 64'(rh)) * (mant >> 14);
    kelvin   = 64'(64'sd27315 + tc);
    quot     = prod / kelvin;
    sh       = 64'sd32 - whole;
    ah       = (sh >= 64) ? 64'd0 : (quot >> sh);
    if (ah > 64'(AH_CEIL)) ah = 64'(AH_CEIL);
    return ah[AH_W-1:0];
  endfunction

  task automatic ah_send(input logic signed [TEMP_W-1:0] temp, input logic [RH_W-1:0] rh,
                         input logic typed, input logic [AH_W-1:0] typed_ah);
    start          <= 1'b1;
    temp_centi_c_i <= temp;
    rh_centi_pct_i <= rh;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (typed) ah_expected.push_back(typed_ah);
    else ah_expected.push_back(ah_predict(temp, rh));
    samples_sent++;
  endtask

  // With probability pct, drop start for a geometric run of cycles; scramble the fields meanwhile.
  task automatic ah_idle(input int pct);
    if (int'($urandom_range(99)) < pct) begin
      start <= 1'b0;
      do begin
        temp_centi_c_i <= TEMP_W'($urandom);
        rh_centi_pct_i <= RH_W'($urandom);
        @(posedge clk_i);
      end while (int'($urandom_range(99)) < pct);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || valid_o) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (valid_o) begin
        results_seen++;
        if (ah_expected.size() == 0) begin
          $error("abs_humidity_mg_m3: expected none, got %0d", abs_humidity_mg_m3_o);
          mismatch_count++;
        end else begin
          ah_want = ah_expected.pop_front();
          if (abs_humidity_mg_m3_o !== ah_want) begin
            $error("abs_humidity_mg_m3: expected %0d, got %0d", ah_want,
                   abs_humidity_mg_m3_o);
            mismatch_count++;
          end
        end
      end
    end
  end

  initial begin
    wait (rst_ni);
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    logic [63:0]              z;
    logic [63:0]              term;
    logic [63:0]              sum;
    int                       tv;
    logic signed [TEMP_W-1:0] temp;
    logic [RH_W-1:0]          rh;
    int                       idle_pct [4];
    idle_pct = '{0, 73, 0, 11};
    // 2^(i/N) in Q30 by a 24-term exp series
    for (int i = 0; i <= POW2_ENTRIES; i++) begin
      z    = (64'(i) * LN2_Q30_C) / 64'(POW2_ENTRIES);
      term = UNITY_Q30;
      sum  = UNITY_Q30;
      for (int k = 1; k <= 24; k++) begin
        term = ((term * z) >> 30) / 64'(k);
        sum  = sum + term;
      end
      pow2_q30[i] = sum;
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int c = 0; c < CORNER_COUNT; c++) begin
      ah_send(AH_CORNERS[c].temp, AH_CORNERS[c].rh, AH_CORNERS[c].typed, AH_CORNERS[c].ah);
      if (c >= CORNER_COUNT / 2) ah_idle(40);
    end

    for (int ph = 0; ph < 4; ph++) begin
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if ($urandom_range(9) < 8) begin
          tv   = int'($urandom_range(16500)) - 4000;
          temp = tv[TEMP_W-1:0];
          rh   = RH_W'($urandom_range(10000));
        end else begin
          temp = TEMP_W'($urandom);
          rh   = RH_W'($urandom);
        end
        ah_send(temp, rh, 1'b0, '0);
        ah_idle(idle_pct[ph]);
      end
    end
    start <= 1'b0;

    while (ah_expected.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d samples (%0d corner rows, rest random in-range and full-width), %0d results",
             samples_sent, CORNER_COUNT, results_seen);
    $display("Pacing covered back-to-back issue and sender gaps of 73 and 11 percent");
    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
